@@ design/lssr_pkg.sv @@
// Shared types, constants and helper functions of the lidar scan row segmenter.
package lssr_pkg;

  // Grid limits
  localparam int MAX_COLUMNS = 32768;
  localparam int MAX_ROWS    = 128;
  localparam int COL_TOP_I   = ((MAX_COLUMNS - 1) < 32767) ? (MAX_COLUMNS - 1) : 32767;
  localparam int ROW_TOP_I   = ((MAX_ROWS - 1) < 127) ? (MAX_ROWS - 1) : 127;

  localparam logic [15:0] COL_TOP = 16'(COL_TOP_I);
  localparam logic [7:0]  ROW_TOP = 8'(ROW_TOP_I);
  localparam logic [7:0]  ROW_LIM = 8'(ROW_TOP_I + 1);

  // Reset values and saturation limits
  localparam logic [14:0] TOL_RESET = 15'd1000;
  localparam logic [14:0] NONE_KEPT = 15'h7FFF;
  localparam logic [21:0] SUM_MAX   = 22'h3FFFFF;
  localparam logic [2:0]  CHG_MAX   = 3'd7;
  localparam logic [2:0]  CHG_CLOSE = 3'd4;

  // Quadrant codes; the origin is a quadrant of its own
  typedef enum logic [2:0] {
    QD_PX_PY = 3'd0,  // x>0,  y>=0
    QD_PX_NY = 3'd1,  // x>=0, y<0
    QD_NX_NY = 3'd2,  // x<0,  y<=0
    QD_NX_PY = 3'd3,  // x<=0, y>0
    QD_ORIG  = 3'd4
  } quad_t;

  // Angle class of a point
  typedef enum logic [1:0] {
    ANG_NONE  = 2'd0,
    ANG_UP    = 2'd1,
    ANG_DOWN  = 2'd2,
    ANG_SLOPE = 2'd3
  } ang_kind_t;

  // Input beat payload
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               frame_start;
  } pt_item_t;

  // Result beat payload
  typedef struct packed {
    logic [14:0] column;
    logic [6:0]  row;
    logic        row_closed;
    logic        row_kept;
    logic [7:0]  kept_rows;
    logic [14:0] min_kept_width;
    logic        overflow;
  } res_item_t;

  function automatic quad_t quadrant_of(logic signed [15:0] x, logic signed [15:0] y);
    logic x_pos, x_neg, y_pos, y_neg;
    x_neg = x[15];
    y_neg = y[15];
    x_pos = !x[15] && (x != 16'sd0);
    y_pos = !y[15] && (y != 16'sd0);
    if (x_pos && !y_neg)      return QD_PX_PY;
    else if (!x_neg && y_neg) return QD_PX_NY;
    else if (x_neg && !y_pos) return QD_NX_NY;
    else if (!x_pos && y_pos) return QD_NX_PY;
    else                      return QD_ORIG;
  endfunction

  function automatic ang_kind_t angle_kind(logic signed [15:0] x, logic signed [15:0] y);
    if (x != 16'sd0)      return ANG_SLOPE;
    else if (y > 16'sd0)  return ANG_UP;
    else if (y < 16'sd0)  return ANG_DOWN;
    else                  return ANG_NONE;
  endfunction

endpackage

@@ design/lssr_if.sv @@
// Valid/ready channel interfaces for point beats and result beats.
interface lssr_pt_if
  import lssr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               frame_start;

  modport source (output valid, output pos_x, output pos_y, output frame_start, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input frame_start, output ready);
endinterface

interface lssr_res_if
  import lssr_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [14:0] column;
  logic [6:0]  row;
  logic        row_closed;
  logic        row_kept;
  logic [7:0]  kept_rows;
  logic [14:0] min_kept_width;
  logic        overflow;

  modport source (output valid, output column, output row, output row_closed,
                  output row_kept, output kept_rows, output min_kept_width,
                  output overflow, input ready);
  modport sink   (input valid, input column, input row, input row_closed,
                  input row_kept, input kept_rows, input min_kept_width,
                  input overflow, output ready);
endinterface

@@ design/lssr_in_reg.sv @@
// Input register stage: captures one point beat when it is empty or the pipe advances.
module lssr_in_reg
  import lssr_pkg::*;
  (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pt_item_t in_item,
  input  logic     adv,       // downstream takes the held beat this cycle
  output logic     hold_valid,
  output pt_item_t hold_item
  );

  logic     vld_r, vld_nxt;
  pt_item_t item_r;

  // Accept when empty or when the held beat moves on
  assign in_ready = !vld_r || adv;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = vld_r;
  assign hold_item  = item_r;

endmodule

@@ design/lssr_core.sv @@
// Segmenter state and the combinational per-point update logic.
module lssr_core
  import lssr_pkg::*;
  (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        step,      // held point is processed at this edge
  input  pt_item_t    item,
  output res_item_t   res
  );

  // Configuration and state registers
  logic [14:0]        tol_r;
  logic signed [15:0] ref_x_r, ref_y_r;
  quad_t              cq_r, cq_nxt;
  logic [2:0]         chg_r, chg_nxt;
  logic [15:0]        wc_r, wc_nxt;
  logic [7:0]         hc_r, hc_nxt;
  logic [21:0]        sum_r, sum_nxt;
  logic [14:0]        min_r, min_nxt;

  // Frame-start adjusted view of the state
  logic signed [15:0] x, y, rx_e, ry_e;
  quad_t              q_pt, cq_e;
  logic [2:0]         chg_e, chg_inc;
  logic [15:0]        wc_e, wc_base;
  logic [7:0]         hc_e;
  logic [21:0]        sum_e;
  logic [14:0]        min_e;
  logic               fs;

  // Angle test
  ang_kind_t          kt, kr;
  logic signed [31:0] lhs, rhs;
  logic               same_side, ang_ok;

  // Width test
  logic [23:0]        prod_wh;
  logic [22:0]        tol_h;
  logic signed [25:0] diff;
  logic [24:0]        diff_abs;
  logic               pass, closed, kept;
  logic [22:0]        sum_add;

  // Result fields
  logic [15:0]        col_v;
  logic [7:0]         row_v;
  logic               col_ovf, row_ovf;

  assign x  = item.pos_x;
  assign y  = item.pos_y;
  assign fs = item.frame_start;

  // Frame start replaces reference and clears counts before the point is used
  always_comb begin
    q_pt  = quadrant_of(x, y);
    rx_e  = fs ? x : ref_x_r;
    ry_e  = fs ? y : ref_y_r;
    cq_e  = fs ? q_pt : cq_r;
    chg_e = fs ? 3'd0 : chg_r;
    wc_e  = fs ? 16'd0 : wc_r;
    hc_e  = fs ? 8'd0 : hc_r;
    sum_e = fs ? 22'd0 : sum_r;
    min_e = fs ? NONE_KEPT : min_r;
  end

  // Quadrant change counter, sticks at seven
  assign chg_inc = ((q_pt != cq_e) && (chg_e != CHG_MAX)) ? chg_e + 3'd1 : chg_e;

  // Angle not above reference, compared as cross products of the slopes
  assign kt        = angle_kind(x, y);
  assign kr        = angle_kind(rx_e, ry_e);
  assign lhs       = y * rx_e;
  assign rhs       = ry_e * x;
  assign same_side = (!x[15] && (x != 16'sd0)) == (!rx_e[15] && (rx_e != 16'sd0));

  always_comb begin
    priority if (kt == ANG_NONE || kr == ANG_NONE) begin
      ang_ok = 1'b0;
    end else if (kr == ANG_UP || kt == ANG_DOWN) begin
      ang_ok = 1'b1;
    end else if (kt == ANG_UP || kr == ANG_DOWN) begin
      ang_ok = 1'b0;
    end else if (same_side) begin
      ang_ok = (lhs <= rhs);
    end else begin
      ang_ok = (lhs >= rhs);
    end
  end

  assign closed = (chg_inc == CHG_CLOSE) && ang_ok;

  // Width test: |w*h - sum| < tol*h, first row passes on nonzero tolerance
  assign prod_wh  = wc_e * hc_e;
  assign tol_h    = tol_r * hc_e;
  assign diff     = $signed({2'b00, prod_wh}) - $signed({4'b0000, sum_e});
  assign diff_abs = diff[25] ? 25'(-diff) : diff[24:0];
  assign pass     = (hc_e == 8'd0) ? (tol_r != 15'd0) : (diff_abs < {2'b00, tol_h});
  assign kept     = closed && pass;

  // Next state
  assign sum_add = {1'b0, sum_e} + {7'd0, wc_e};

  always_comb begin
    min_nxt = min_e;
    hc_nxt  = hc_e;
    sum_nxt = sum_e;
    if (kept) begin
      if (wc_e < {1'b0, min_e}) begin
        min_nxt = wc_e[14:0];
      end
      if (hc_e < ROW_LIM) begin
        hc_nxt  = hc_e + 8'd1;
        sum_nxt = sum_add[22] ? SUM_MAX : sum_add[21:0];
      end
    end
  end

  assign chg_nxt = closed ? 3'd0 : chg_inc;
  assign cq_nxt  = q_pt;
  assign wc_base = closed ? 16'd0 : wc_e;
  assign wc_nxt  = (wc_base <= COL_TOP) ? wc_base + 16'd1 : wc_base;

  // Saturated grid position
  assign col_ovf = wc_base > COL_TOP;
  assign col_v   = col_ovf ? COL_TOP : wc_base;
  assign row_ovf = hc_nxt > ROW_TOP;
  assign row_v   = row_ovf ? ROW_TOP : hc_nxt;

  always_comb begin
    res.column         = col_v[14:0];
    res.row            = row_v[6:0];
    res.row_closed     = closed;
    res.row_kept       = kept;
    res.kept_rows      = hc_nxt;
    res.min_kept_width = min_nxt;
    res.overflow       = col_ovf || row_ovf;
  end

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // Segmenter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= 16'sd0;
      ref_y_r <= 16'sd0;
      cq_r    <= QD_PX_PY;
      chg_r   <= 3'd0;
      wc_r    <= 16'd0;
      hc_r    <= 8'd0;
      sum_r   <= 22'd0;
      min_r   <= NONE_KEPT;
    end else if (step) begin
      ref_x_r <= rx_e;
      ref_y_r <= ry_e;
      cq_r    <= cq_nxt;
      chg_r   <= chg_nxt;
      wc_r    <= wc_nxt;
      hc_r    <= hc_nxt;
      sum_r   <= sum_nxt;
      min_r   <= min_nxt;
    end
  end

endmodule

@@ design/lssr_out_reg.sv @@
// Result register stage: holds one result beat until the receiver takes it.
module lssr_out_reg
  import lssr_pkg::*;
  (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load_valid,  // a new result is offered
  input  res_item_t load_item,
  output logic      adv,         // register can take a result this cycle
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t out_item
  );

  logic      vld_r, vld_nxt;
  res_item_t item_r;

  // Free when empty or when the receiver takes the held beat
  assign adv     = !vld_r || out_ready;
  assign vld_nxt = adv ? load_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load_valid) begin
      item_r <= load_item;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule

@@ design/lidar_scan_row_segmenter_top.sv @@
// Top level of the lidar scan row segmenter.
// Usage:
//   in_pt  : point beats (pos_x, pos_y signed Q8.8, frame_start), valid/ready.
//   out_res: one result beat per point beat (column, row, row_closed,
//            row_kept, kept_rows, min_kept_width, overflow), valid/ready.
//   cfg_wr_en/cfg_wr_data: writes width_tolerance; write only while idle.
// Pipeline: input register -> combinational segment logic -> result register.
// A point accepted into the input register is offered as a result beat once
// it moves into the result register, which it does when that register is free.
// Throughput is one point per cycle while the receiver does not stall; the state
// update (quadrant count, angle cross products, width test) is combinational.
// Reset (rst_n low, synchronous) empties both registers, sets the tolerance
// to 1000, clears all counts and sets min_kept_width to 32767.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and in_pt.ready drops after at most one more beat is taken.
module lidar_scan_row_segmenter_top
  import lssr_pkg::*;
  (
  input  logic        clk,
  input  logic        rst_n,
  lssr_pt_if.sink     in_pt,
  lssr_res_if.source  out_res,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data
  );

  pt_item_t  in_item, hold_item;
  res_item_t core_res, out_item;
  logic      hold_valid, adv, step;

  assign in_item.pos_x       = in_pt.pos_x;
  assign in_item.pos_y       = in_pt.pos_y;
  assign in_item.frame_start = in_pt.frame_start;

  lssr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_pt.valid),
    .in_ready   (in_pt.ready),
    .in_item    (in_item),
    .adv        (adv),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // State advances only when the held point moves into the result register
  assign step = hold_valid && adv;

  lssr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (hold_item),
    .res         (core_res)
  );

  lssr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (hold_valid),
    .load_item  (core_res),
    .adv        (adv),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .out_item   (out_item)
  );

  assign out_res.column         = out_item.column;
  assign out_res.row            = out_item.row;
  assign out_res.row_closed     = out_item.row_closed;
  assign out_res.row_kept       = out_item.row_kept;
  assign out_res.kept_rows      = out_item.kept_rows;
  assign out_res.min_kept_width = out_item.min_kept_width;
  assign out_res.overflow       = out_item.overflow;

endmodule

@@ design/lssr_checker.sv @@
// Port-level checks of the segmenter and their binding to the top level.
module lssr_checker
  import lssr_pkg::*;
  (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] column,
  input logic [6:0]  row,
  input logic        row_closed,
  input logic        row_kept,
  input logic [7:0]  kept_rows,
  input logic        overflow
  );

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result beat stays valid and keeps column, row, row_closed, row_kept and kept_rows
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(column) && $stable(row)
      && $stable(row_closed) && $stable(row_kept) && $stable(kept_rows))
    else $error("stalled result beat changed");

  // Only a closed row can be kept
  a_kept_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && row_kept |-> row_closed)
    else $error("row kept without close");

  // Closing point starts a new row at column zero
  a_close_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && row_closed |-> column == 15'd0)
    else $error("closing point not at column zero");

  // Row tracks kept count unless saturated
  a_row_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, row} == kept_rows) || overflow)
    else $error("row differs from kept count without overflow");

endmodule

bind lidar_scan_row_segmenter_top lssr_checker u_lssr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .column     (out_res.column),
  .row        (out_res.row),
  .row_closed (out_res.row_closed),
  .row_kept   (out_res.row_kept),
  .kept_rows  (out_res.kept_rows),
  .overflow   (out_res.overflow)
);
